// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file mde_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication, checked through reset as well.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/mde_pkg.sv =====
// ----------------------------------------------------------------------------
// mde_pkg
// Types, opcode and funct codes, and control encodings for the MIPS32
// decode/execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mde_pkg;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] pc;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
    logic [31:0] rd_old_value;
  } mde_in_t;

  typedef struct packed {
    logic [31:0] exec_value;
    logic [4:0]  dest_reg;
    logic        reg_write;
    logic        mem_read;
    logic        mem_write;
    logic        branch_taken;
    logic [31:0] next_pc;
    logic        illegal_op;
  } mde_out_t;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // SPECIAL funct codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_MOVZ = 6'h0A;
  localparam logic [5:0] FN_MOVN = 6'h0B;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  // REGIMM rt code
  localparam logic [4:0] RT_BLTZ = 5'h00;

  localparam logic [4:0] REG_RA = 5'd31;

  typedef enum logic [3:0] {
    ALU_NONE,
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_XOR,
    ALU_NOR,
    ALU_SLL,
    ALU_SRL,
    ALU_SLT,
    ALU_SLTU,
    ALU_MOVZ,
    ALU_MOVN,
    ALU_LINK
  } alu_op_t;

  typedef enum logic [1:0] {
    OPB_RT,
    OPB_SEXT,
    OPB_ZEXT
  } opb_sel_t;

  typedef enum logic [1:0] {
    DEST_NONE,
    DEST_RD,
    DEST_RT,
    DEST_RA
  } dest_sel_t;

  typedef enum logic [2:0] {
    BR_NONE,
    BR_EQ,
    BR_NE,
    BR_LEZ,
    BR_LTZ,
    BR_GTZ,
    BR_JUMP,
    BR_REG
  } br_kind_t;

  typedef struct packed {
    alu_op_t   alu_op;
    opb_sel_t  opb_sel;
    dest_sel_t dest_sel;
    br_kind_t  br_kind;
    logic      reg_write;
    logic      mem_read;
    logic      mem_write;
    logic      illegal;
  } mde_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/mips_decode_execute_unit.sv =====
// ----------------------------------------------------------------------------
// mips_decode_execute_unit
// MIPS32 integer decode/execute: ALU, destination, memory flags, branch
// decision and next PC for one instruction word per cycle.
//
//   channel | signals                       | word
//   --------+-------------------------------+-----------
//   in      | in_valid, in_ready, in_data   | mde_in_t
//   out     | out_valid, out_ready, out_data| mde_out_t
//
// One word per cycle sustained while out is not stalled.
// Latency is set by the input register and the result register around the
// decode/execute logic.
// Reset clears both valid bits; payload registers are not reset.
// A stall on out holds the result; in keeps accepting while the input
// register can drain into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mips_decode_execute_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mde_pkg::mde_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mde_pkg::mde_out_t      out_data
);
  import mde_pkg::*;

  logic      stage_valid;
  mde_in_t   stage_data;
  mde_ctrl_t ctrl;
  mde_out_t  result;
  logic      out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !stage_valid || out_free;

  mde_decode u_decode (
    .instr_word (stage_data.instr_word),
    .ctrl       (ctrl)
  );

  mde_execute u_execute (
    .in_word (stage_data),
    .ctrl    (ctrl),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_data <= in_data;
    end
    if (stage_valid && out_free) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mde_decode.sv =====
// ----------------------------------------------------------------------------
// mde_decode
// Turn an instruction word into the control bundle for the execute logic.
// ----------------------------------------------------------------------------
`default_nettype none

module mde_decode (
  input  wire logic [31:0]       instr_word,
  output mde_pkg::mde_ctrl_t     ctrl
);
  import mde_pkg::*;

  logic [5:0] op;
  logic [5:0] fn;
  logic [4:0] rt;

  assign op = instr_word[31:26];
  assign fn = instr_word[5:0];
  assign rt = instr_word[20:16];

  always_comb begin
    ctrl           = '0;
    ctrl.alu_op    = ALU_NONE;
    ctrl.opb_sel   = OPB_RT;
    ctrl.dest_sel  = DEST_NONE;
    ctrl.br_kind   = BR_NONE;
    case (op)
      OP_SPECIAL: begin
        ctrl.dest_sel  = DEST_RD;
        ctrl.reg_write = 1'b1;
        case (fn)
          FN_SLL:  ctrl.alu_op = ALU_SLL;
          FN_SRL:  ctrl.alu_op = ALU_SRL;
          FN_JR: begin
            ctrl.dest_sel  = DEST_NONE;
            ctrl.reg_write = 1'b0;
            ctrl.br_kind   = BR_REG;
          end
          FN_MOVZ: ctrl.alu_op = ALU_MOVZ;
          FN_MOVN: ctrl.alu_op = ALU_MOVN;
          FN_ADDU: ctrl.alu_op = ALU_ADD;
          FN_SUB, FN_SUBU: ctrl.alu_op = ALU_SUB;
          FN_AND:  ctrl.alu_op = ALU_AND;
          FN_OR:   ctrl.alu_op = ALU_OR;
          FN_XOR:  ctrl.alu_op = ALU_XOR;
          FN_NOR:  ctrl.alu_op = ALU_NOR;
          FN_SLT:  ctrl.alu_op = ALU_SLT;
          FN_SLTU: ctrl.alu_op = ALU_SLTU;
          default: begin
            ctrl.dest_sel  = DEST_NONE;
            ctrl.reg_write = 1'b0;
            ctrl.illegal   = 1'b1;
          end
        endcase
      end
      OP_J: ctrl.br_kind = BR_JUMP;
      OP_JAL: begin
        ctrl.br_kind   = BR_JUMP;
        ctrl.alu_op    = ALU_LINK;
        ctrl.dest_sel  = DEST_RA;
        ctrl.reg_write = 1'b1;
      end
      OP_REGIMM: begin
        if (rt == RT_BLTZ) begin
          ctrl.br_kind = BR_LTZ;
        end else begin
          ctrl.illegal = 1'b1;
        end
      end
      OP_BEQ:  ctrl.br_kind = BR_EQ;
      OP_BNE:  ctrl.br_kind = BR_NE;
      OP_BLEZ: ctrl.br_kind = BR_LEZ;
      OP_BGTZ: ctrl.br_kind = BR_GTZ;
      OP_ADDI, OP_ADDIU, OP_LW, OP_SW: begin
        ctrl.alu_op    = ALU_ADD;
        ctrl.opb_sel   = OPB_SEXT;
        ctrl.dest_sel  = DEST_RT;
        ctrl.reg_write = (op != OP_SW);
        ctrl.mem_read  = (op == OP_LW);
        ctrl.mem_write = (op == OP_SW);
      end
      OP_SLTI, OP_SLTIU: begin
        ctrl.alu_op    = (op == OP_SLTI) ? ALU_SLT : ALU_SLTU;
        ctrl.opb_sel   = OPB_SEXT;
        ctrl.dest_sel  = DEST_RT;
        ctrl.reg_write = 1'b1;
      end
      OP_ANDI, OP_ORI, OP_XORI: begin
        ctrl.alu_op    = (op == OP_ANDI) ? ALU_AND : ((op == OP_ORI) ? ALU_OR : ALU_XOR);
        ctrl.opb_sel   = OPB_ZEXT;
        ctrl.dest_sel  = DEST_RT;
        ctrl.reg_write = 1'b1;
      end
      default: ctrl.illegal = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mde_execute.sv =====
// ----------------------------------------------------------------------------
// mde_execute
// ALU, destination select and branch/jump resolution for one decoded word.
// ----------------------------------------------------------------------------
`default_nettype none

module mde_execute (
  input  wire mde_pkg::mde_in_t   in_word,
  input  wire mde_pkg::mde_ctrl_t ctrl,
  output mde_pkg::mde_out_t       result
);
  import mde_pkg::*;

  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] opb;
  logic [31:0] simm;
  logic [31:0] zimm;
  logic [31:0] seq_pc;
  logic [4:0]  shamt;
  logic        cond;
  logic [31:0] alu_out;
  logic [4:0]  dest;
  logic [31:0] npc;

  assign a      = in_word.rs_value;
  assign b      = in_word.rt_value;
  assign shamt  = in_word.instr_word[10:6];
  assign simm   = {{16{in_word.instr_word[15]}}, in_word.instr_word[15:0]};
  assign zimm   = {16'h0000, in_word.instr_word[15:0]};
  assign seq_pc = in_word.pc + 32'd1;

  always_comb begin
    case (ctrl.opb_sel)
      OPB_SEXT: opb = simm;
      OPB_ZEXT: opb = zimm;
      default:  opb = b;
    endcase
  end

  always_comb begin
    case (ctrl.alu_op)
      ALU_ADD:  alu_out = a + opb;
      ALU_SUB:  alu_out = a - opb;
      ALU_AND:  alu_out = a & opb;
      ALU_OR:   alu_out = a | opb;
      ALU_XOR:  alu_out = a ^ opb;
      ALU_NOR:  alu_out = ~(a | opb);
      ALU_SLL:  alu_out = b << shamt;
      ALU_SRL:  alu_out = b >> shamt;
      ALU_SLT:  alu_out = {31'd0, $signed(a) < $signed(opb)};
      ALU_SLTU: alu_out = {31'd0, a < opb};
      ALU_MOVZ: alu_out = (b == 32'd0) ? a : in_word.rd_old_value;
      ALU_MOVN: alu_out = (b != 32'd0) ? a : in_word.rd_old_value;
      ALU_LINK: alu_out = in_word.pc + 32'd2;
      default:  alu_out = '0;
    endcase
  end

  always_comb begin
    case (ctrl.dest_sel)
      DEST_RD: dest = in_word.instr_word[15:11];
      DEST_RT: dest = in_word.instr_word[20:16];
      DEST_RA: dest = REG_RA;
      default: dest = '0;
    endcase
  end

  always_comb begin
    case (ctrl.br_kind)
      BR_EQ:   cond = (a == b);
      BR_NE:   cond = (a != b);
      BR_LEZ:  cond = (a == 32'd0) || a[31];
      BR_LTZ:  cond = a[31];
      BR_GTZ:  cond = (a != 32'd0) && !a[31];
      BR_JUMP: cond = 1'b1;
      BR_REG:  cond = 1'b1;
      default: cond = 1'b0;
    endcase
  end

  always_comb begin
    npc = seq_pc;
    if (cond) begin
      case (ctrl.br_kind)
        BR_JUMP: npc = {seq_pc[31:28], 2'b00, in_word.instr_word[25:0]};
        BR_REG:  npc = a;
        default: npc = seq_pc + simm;
      endcase
    end
  end

  assign result = {alu_out, dest, ctrl.reg_write, ctrl.mem_read, ctrl.mem_write,
                   cond, npc, ctrl.illegal};

endmodule

`default_nettype wire

// ===== rtl/mde_checker.sv =====
// ----------------------------------------------------------------------------
// mde_checker
// Port-level checks on flow and latency of the decode/execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mde_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire mde_pkg::mde_out_t out_data
);

  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)
  `ASSERT_IMPLY(a_ready_when_empty, clk, rst, !out_valid, in_ready)
  `ASSERT_NEXT(a_two_cycle_latency, clk, rst, in_valid && in_ready ##1 out_ready, out_valid)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind mips_decode_execute_unit mde_checker u_mde_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for mips_decode_execute_unit. A directed set of
// instruction words hits every supported opcode and funct but BNE, ANDI,
// ORI, SUBU, AND, OR, the wrap and sign corners, REGIMM and opcode/funct
// decode errors, and jump region edges. About 1400 random words follow,
// mostly legal encodings with corner operands plus some raw noise. Both
// channels idle at random, with stretches of back-to-back traffic. A
// scoreboard predicts every result and compares all its fields, in order.
// ----------------------------------------------------------------------------
module tb;
  import mde_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_WORDS = 1375;
  localparam int MAX_REPORTS  = 10;

  localparam logic [5:0] OP_UNUSED = 6'h3F;
  localparam logic [5:0] FN_UNUSED = 6'h3F;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  mde_in_t   in_data;
  logic      out_valid;
  logic      out_ready;
  mde_out_t  out_data;

  logic [5:0] legal_ops [17] = '{OP_SPECIAL, OP_REGIMM, OP_J, OP_JAL, OP_BEQ, OP_BNE,
                                 OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU,
                                 OP_ANDI, OP_ORI, OP_XORI, OP_LW, OP_SW};
  logic [5:0] legal_functs [14] = '{FN_SLL, FN_SRL, FN_JR, FN_MOVZ, FN_MOVN, FN_ADDU,
                                    FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR,
                                    FN_SLT, FN_SLTU};

  class exec_ledger;
    mde_out_t pending_results[$];
    int mismatches;
    int words_checked;
    int writes;
    int loads;
    int stores;
    int taken;
    int illegal;

    function mde_out_t execute_instr(mde_in_t w);
      logic [5:0]  op;
      logic [5:0]  fn;
      logic [4:0]  rt;
      logic [4:0]  rd;
      logic [4:0]  sh;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] zimm;
      logic [31:0] simm;
      logic [31:0] seq;
      logic        cond;
      mde_out_t    r;
      op   = w.instr_word[31:26];
      rt   = w.instr_word[20:16];
      rd   = w.instr_word[15:11];
      sh   = w.instr_word[10:6];
      fn   = w.instr_word[5:0];
      a    = w.rs_value;
      b    = w.rt_value;
      zimm = {16'h0000, w.instr_word[15:0]};
      simm = {{16{w.instr_word[15]}}, w.instr_word[15:0]};
      seq  = w.pc + 32'd1;
      cond = 1'b0;
      r = '0;
      r.next_pc = seq;
      case (op)
        OP_SPECIAL: begin
          r.dest_reg  = rd;
          r.reg_write = 1'b1;
          case (fn)
            FN_SLL:  r.exec_value = b << sh;
            FN_SRL:  r.exec_value = b >> sh;
            FN_JR: begin
              r.reg_write    = 1'b0;
              r.dest_reg     = '0;
              r.branch_taken = 1'b1;
              r.next_pc      = a;
            end
            FN_MOVZ: r.exec_value = (b == 32'd0) ? a : w.rd_old_value;
            FN_MOVN: r.exec_value = (b != 32'd0) ? a : w.rd_old_value;
            FN_ADDU: r.exec_value = a + b;
            FN_SUB, FN_SUBU: r.exec_value = a - b;
            FN_AND:  r.exec_value = a & b;
            FN_OR:   r.exec_value = a | b;
            FN_XOR:  r.exec_value = a ^ b;
            FN_NOR:  r.exec_value = ~(a | b);
            FN_SLT:  r.exec_value = {31'd0, ($signed(a) < $signed(b))};
            FN_SLTU: r.exec_value = {31'd0, (a < b)};
            default: r.illegal_op = 1'b1;
          endcase
        end
        OP_J, OP_JAL: begin
          r.branch_taken = 1'b1;
          r.next_pc      = {seq[31:28], 2'b00, w.instr_word[25:0]};
          if (op == OP_JAL) begin
            r.exec_value = w.pc + 32'd2;
            r.dest_reg   = REG_RA;
            r.reg_write  = 1'b1;
          end
        end
        OP_REGIMM, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
          case (op)
            OP_REGIMM: cond = a[31];
            OP_BEQ:    cond = (a == b);
            OP_BNE:    cond = (a != b);
            OP_BLEZ:   cond = (a == 32'd0) || a[31];
            default:   cond = (a != 32'd0) && !a[31];
          endcase
          if (op == OP_REGIMM && rt != RT_BLTZ) begin
            r.illegal_op = 1'b1;
          end else if (cond) begin
            r.branch_taken = 1'b1;
            r.next_pc      = seq + simm;
          end
        end
        OP_ADDI, OP_ADDIU: begin
          r.exec_value = a + simm;
          r.dest_reg   = rt;
          r.reg_write  = 1'b1;
        end
        OP_SLTI: begin
          r.exec_value = {31'd0, ($signed(a) < $signed(simm))};
          r.dest_reg   = rt;
          r.reg_write  = 1'b1;
        end
        OP_SLTIU: begin
          r.exec_value = {31'd0, (a < simm)};
          r.dest_reg   = rt;
          r.reg_write  = 1'b1;
        end
        OP_ANDI: begin
          r.exec_value = a & zimm;
          r.dest_reg   = rt;
          r.reg_write  = 1'b1;
        end
        OP_ORI: begin
          r.exec_value = a | zimm;
          r.dest_reg   = rt;
          r.reg_write  = 1'b1;
        end
        OP_XORI: begin
          r.exec_value = a ^ zimm;
          r.dest_reg   = rt;
          r.reg_write  = 1'b1;
        end
        OP_LW: begin
          r.exec_value = a + simm;
          r.dest_reg   = rt;
          r.reg_write  = 1'b1;
          r.mem_read   = 1'b1;
        end
        OP_SW: begin
          r.exec_value = a + simm;
          r.dest_reg   = rt;
          r.mem_write  = 1'b1;
        end
        default: r.illegal_op = 1'b1;
      endcase
      if (r.illegal_op) begin
        r = '0;
        r.illegal_op = 1'b1;
        r.next_pc    = seq;
      end
      return r;
    endfunction

    function void add_instr(mde_in_t w);
      pending_results.push_back(execute_instr(w));
    endfunction

    function void match_result(mde_out_t got);
      mde_out_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word: %p", got);
        return;
      end
      want = pending_results.pop_front();
      words_checked++;
      writes  += want.reg_write;
      loads   += want.mem_read;
      stores  += want.mem_write;
      taken   += want.branch_taken;
      illegal += want.illegal_op;
      if (got.exec_value !== want.exec_value || got.dest_reg !== want.dest_reg ||
          got.reg_write !== want.reg_write || got.mem_read !== want.mem_read ||
          got.mem_write !== want.mem_write || got.branch_taken !== want.branch_taken ||
          got.next_pc !== want.next_pc || got.illegal_op !== want.illegal_op) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result %0d mismatch", words_checked);
          $display("  exp res=%h dst=%0d wr=%b rd=%b st=%b tk=%b npc=%h ill=%b",
                   want.exec_value, want.dest_reg, want.reg_write, want.mem_read,
                   want.mem_write, want.branch_taken, want.next_pc, want.illegal_op);
          $display("  got res=%h dst=%0d wr=%b rd=%b st=%b tk=%b npc=%h ill=%b",
                   got.exec_value, got.dest_reg, got.reg_write, got.mem_read,
                   got.mem_write, got.branch_taken, got.next_pc, got.illegal_op);
        end
      end
    endfunction
  endclass

  exec_ledger sb;
  mde_in_t    instr_stream[$];
  bit         in_steady;
  bit         out_steady;
  int         directed_count;

  mips_decode_execute_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rd, logic [4:0] sh);
    return {OP_SPECIAL, 5'd3, 5'd4, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rt, logic [15:0] imm);
    return {op, 5'd6, rt, imm};
  endfunction

  function automatic logic [31:0] enc_j(logic [5:0] op, logic [25:0] target);
    return {op, target};
  endfunction

  function automatic logic [31:0] corner_value();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic mde_in_t random_instr();
    mde_in_t    w;
    logic [5:0] op;
    w.pc           = corner_value();
    w.rs_value     = corner_value();
    w.rt_value     = corner_value();
    w.rd_old_value = $urandom;
    w.instr_word   = $urandom;
    if ($urandom_range(0, 99) < 85) begin
      op = legal_ops[$urandom_range(0, 16)];
      w.instr_word[31:26] = op;
      if (op == OP_SPECIAL)
        w.instr_word[5:0] = legal_functs[$urandom_range(0, 13)];
      if (op == OP_REGIMM && $urandom_range(0, 7) != 0)
        w.instr_word[20:16] = RT_BLTZ;
      case ($urandom_range(0, 7))
        0: w.instr_word[15:0] = 16'h0000;
        1: w.instr_word[15:0] = 16'h7FFF;
        2: w.instr_word[15:0] = 16'h8000;
        3: w.instr_word[15:0] = 16'hFFFF;
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0)
        w.rt_value = w.rs_value;
    end
    return w;
  endfunction

  task automatic queue_word(logic [31:0] iw, logic [31:0] pc, logic [31:0] a,
                            logic [31:0] b, logic [31:0] old);
    mde_in_t w;
    w.instr_word   = iw;
    w.pc           = pc;
    w.rs_value     = a;
    w.rt_value     = b;
    w.rd_old_value = old;
    instr_stream.push_back(w);
  endtask

  // Enter and leave at a falling edge.
  task automatic issue_instr(mde_in_t w);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.add_instr(in_data);
      if (out_valid && out_ready)
        sb.match_result(out_data);
    end
  end

  initial begin
    int held;
    int stall;
    held = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (held % 100 == 0)
        out_steady = ($urandom_range(0, 3) == 0);
      stall = out_steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      held++;
      @(negedge clk);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle = 0;
      else
        idle++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    sb        = new();

    queue_word(enc_r(FN_SLL, 5'd1, 5'd31), 32'h0, 32'h0, 32'h8000_0001, 32'h0);
    queue_word(enc_r(FN_SRL, 5'd2, 5'd31), 32'h10, 32'h0, 32'hFFFF_FFFF, 32'h0);
    queue_word(enc_r(FN_JR, 5'd7, 5'd0), 32'h20, 32'hFFFF_FFFF, 32'h0, 32'h0);
    queue_word(enc_r(FN_MOVZ, 5'd8, 5'd0), 32'h21, 32'h1234_5678, 32'h0, 32'hDEAD_BEEF);
    queue_word(enc_r(FN_MOVZ, 5'd8, 5'd0), 32'h22, 32'h1234_5678, 32'h1, 32'hDEAD_BEEF);
    queue_word(enc_r(FN_MOVN, 5'd9, 5'd0), 32'h23, 32'hCAFE_0001, 32'h8000_0000, 32'h5);
    queue_word(enc_r(FN_ADDU, 5'd31, 5'd5), 32'h24, 32'hFFFF_FFFF, 32'h1, 32'h0);
    queue_word(enc_r(FN_SUB, 5'd10, 5'd0), 32'h25, 32'h8000_0000, 32'h1, 32'h0);
    queue_word(enc_r(FN_XOR, 5'd11, 5'd0), 32'h26, 32'hA5A5_A5A5, 32'hFFFF_0000, 32'h0);
    queue_word(enc_r(FN_NOR, 5'd12, 5'd0), 32'h27, 32'h0, 32'h0, 32'h0);
    queue_word(enc_r(FN_SLT, 5'd13, 5'd0), 32'h28, 32'h8000_0000, 32'h1, 32'h0);
    queue_word(enc_r(FN_SLTU, 5'd14, 5'd0), 32'h29, 32'h8000_0000, 32'h1, 32'h0);
    queue_word(enc_i(OP_ADDI, 5'd1, 16'h0001), 32'h30, 32'h7FFF_FFFF, 32'h0, 32'h0);
    queue_word(enc_i(OP_ADDIU, 5'd2, 16'h8000), 32'h31, 32'h0, 32'h0, 32'h0);
    queue_word(enc_i(OP_SLTI, 5'd3, 16'h0000), 32'h32, 32'hFFFF_FFFF, 32'h0, 32'h0);
    queue_word(enc_i(OP_SLTIU, 5'd4, 16'hFFFF), 32'h33, 32'hFFFF_FFFE, 32'h0, 32'h0);
    queue_word(enc_i(OP_XORI, 5'd5, 16'hFFFF), 32'h34, 32'hFFFF_FFFF, 32'h0, 32'h0);
    queue_word(enc_i(OP_LW, 5'd31, 16'h8000), 32'h35, 32'h0000_1000, 32'h0, 32'h0);
    queue_word(enc_i(OP_SW, 5'd0, 16'h7FFF), 32'h36, 32'hFFFF_FFFF, 32'h77, 32'h0);
    queue_word(enc_i(OP_BEQ, 5'd2, 16'h8000), 32'h0, 32'h55, 32'h55, 32'h0);
    queue_word(enc_i(OP_BLEZ, 5'd0, 16'hFFFF), 32'h5, 32'h0, 32'h0, 32'h0);
    queue_word(enc_i(OP_REGIMM, RT_BLTZ, 16'h0004), 32'h40, 32'h8000_0000, 32'h0, 32'h0);
    queue_word(enc_i(OP_BGTZ, 5'd0, 16'h0010), 32'hFFFF_FFF0, 32'h7FFF_FFFF, 32'h0, 32'h0);
    queue_word(enc_i(OP_REGIMM, ~RT_BLTZ, 16'h0004), 32'h41, 32'h8000_0000, 32'h0, 32'h0);
    queue_word(enc_j(OP_J, 26'h3FF_FFFF), 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
    queue_word(enc_j(OP_JAL, 26'h0), 32'hEFFF_FFFF, 32'h0, 32'h0, 32'h0);
    queue_word({OP_UNUSED, 26'h155_5555}, 32'h50, 32'h1, 32'h2, 32'h3);
    queue_word(enc_r(FN_UNUSED, 5'd15, 5'd0), 32'h51, 32'h1, 32'h2, 32'h3);
    directed_count = instr_stream.size();
    repeat (RANDOM_WORDS) instr_stream.push_back(random_instr());

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (instr_stream[i]) begin
      if (i % 100 == 0)
        in_steady = ($urandom_range(0, 3) == 0);
      issue_instr(instr_stream[i]);
    end
    in_valid = 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words (%0d directed), checked %0d results",
             instr_stream.size(), directed_count, sb.words_checked);
    $display("writes %0d, loads %0d, stores %0d, taken %0d, illegal %0d, mismatches %0d",
             sb.writes, sb.loads, sb.stores, sb.taken, sb.illegal, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mde_pkg.sv
rtl/mde_decode.sv
rtl/mde_execute.sv
rtl/mips_decode_execute_unit.sv
rtl/mde_checker.sv
tb/sv/tb.sv
